/* rtl/bmf_pkg.sv */
`timescale 1ns / 1ps

package bmf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 12;
  localparam int PIX_W  = 8;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Six stored rows plus the current pixel make a seven-row column.
  localparam int LINES   = 6;
  localparam int WIN     = 7;
  localparam int SUM_W   = 11;
  localparam int TOTAL_W = 14;

  // floor(t / 49) == (t * 21400) >> 20 for every window total below 43690.
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = TOTAL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_49 = 15'd21400;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
  } line_ctrl_t;

endpackage

/* rtl/bmf_line_cell.sv */
`timescale 1ns / 1ps

module bmf_line_cell import bmf_pkg::*; (
  input  logic             clk_i,
  input  line_ctrl_t       ctrl_i,
  input  logic [PIX_W-1:0] wr_data_i,
  output logic [PIX_W-1:0] row_o
);

  logic [PIX_W-1:0] mem_q [MAX_WIDTH];
  logic [PIX_W-1:0] rd_data_q;
  logic [PIX_W-1:0] byp_q;
  logic             hit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_addr] <= wr_data_i;
    end
  end

  // A read that meets a write to the same column in the same cycle sees the old
  // word, so the new word is kept aside and chosen instead.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[ctrl_i.rd_addr];
      hit_q     <= ctrl_i.wr_en && (ctrl_i.wr_addr == ctrl_i.rd_addr);
      byp_q     <= wr_data_i;
    end
  end

  assign row_o = hit_q ? byp_q : rd_data_q;

endmodule

/* rtl/bmf_sum_cell.sv */
`timescale 1ns / 1ps

module bmf_sum_cell import bmf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [SUM_W-1:0] sum_i,
  output logic [SUM_W-1:0] sum_o
);

  logic [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (shift_i) begin
      sum_q <= sum_i;
    end
  end

  assign sum_o = sum_q;

endmodule

/* rtl/bmf_div49.sv */
`timescale 1ns / 1ps

module bmf_div49 import bmf_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [TOTAL_W-1:0] total_i,
  input  logic               win_i,
  output logic [PIX_W-1:0]   mean_o
);

  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  mean_q;

  assign prod = PROD_W'(total_i) * PROD_W'(RECIP_49);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mean_q <= win_i ? prod[RECIP_SHIFT +: PIX_W] : '0;
    end
  end

  assign mean_o = mean_q;

endmodule

/* rtl/box_mean_filter_7x7_unit.sv */
`timescale 1ns / 1ps

// 7x7 box mean filter for 8-bit greyscale pixels in raster order. One pixel is
// taken every clock cycle unless the output stalls, and one result beat leaves
// per pixel via the pixel, column-sum, window-total and output registers; the
// rate is set by the single read and single write per cycle on each of the six
// line memories (one memory of 2048 pixels per stored row), which form a chain
// that passes each column's history down one row per pixel. The result is the
// truncated mean of the window whose bottom-right corner is the current pixel,
// so it belongs to the pixel three rows up and three columns left; tuser flags
// a full window inside the frame (mean is zero otherwise) and tlast marks the
// last pixel of a frame. Image width and height are written over APB at byte
// addresses 0 and 4; the user must write them only while the stream is idle,
// unchecked by the block; values are clamped to 1..2048. Line memories need
// no clearing: the first six rows of every frame never produce a valid window.

module box_mean_filter_7x7_unit import bmf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // Pixel input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PIX_W-1:0]  s_axis_tdata,   // [7:0] pixel
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PIX_W-1:0]  m_axis_tdata,   // [7:0] mean_value
  output logic              m_axis_tuser,   // [0] window_valid
  output logic              m_axis_tlast    // frame_last
);

  // Configuration registers.
  logic [SIZE_W-1:0] width_q, height_q;
  logic [SIZE_W-1:0] width_eff, height_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_e'(paddr[2]))
        REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx_e'(paddr[2]))
      REG_WIDTH:  prdata = DATA_W'(width_q);
      REG_HEIGHT: prdata = DATA_W'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_comb begin
    if (width_q == '0) begin
      width_eff = SIZE_W'(1);
    end else if (width_q > SIZE_W'(MAX_WIDTH)) begin
      width_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      width_eff = width_q;
    end
    if (height_q == '0) begin
      height_eff = SIZE_W'(1);
    end else if (height_q > SIZE_W'(MAX_HEIGHT)) begin
      height_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      height_eff = height_q;
    end
  end

  // Pipeline handshake: each stage moves when the next one is free.
  logic s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic out_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free, accept;

  assign out_free = !out_vld_q || m_axis_tready;
  assign s3_go    = s3_vld_q && out_free;
  assign s3_free  = !s3_vld_q || out_free;
  assign s2_go    = s2_vld_q && s3_free;
  assign s2_free  = !s2_vld_q || s3_free;
  assign s1_go    = s1_vld_q && s2_free;
  assign s1_free  = !s1_vld_q || s2_free;
  assign accept   = s_axis_tvalid && s1_free;

  assign s_axis_tready = s1_free;

  // Position counters.
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             in_win, row_end, frame_end;

  always_comb begin
    in_win    = (row_q >= ROW_W'(LINES)) && (col_q >= COL_W'(LINES));
    row_end   = (({1'b0, col_q} + (COL_W + 1)'(1)) >= (COL_W + 1)'(width_eff));
    frame_end = row_end &&
                (({1'b0, row_q} + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(height_eff));
    col_d     = col_q + COL_W'(1);
    row_d     = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // First stage: line memories are read while the pixel is taken.
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_win_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_free) begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= s_axis_tdata;
      s1_col_q  <= col_q;
      s1_win_q  <= in_win;
      s1_last_q <= frame_end;
    end
  end

  line_ctrl_t       line_ctrl;
  logic [PIX_W-1:0] row_val [LINES];
  logic [PIX_W-1:0] line_wr [LINES];

  assign line_ctrl.rd_en   = accept;
  assign line_ctrl.rd_addr = col_q;
  assign line_ctrl.wr_en   = s1_go;
  assign line_ctrl.wr_addr = s1_col_q;

  // Each line cell takes the row above it, so a column's history moves down.
  for (genvar k = 0; k < LINES; k++) begin : g_line
    if (k == 0) begin : g_head
      assign line_wr[k] = s1_pix_q;
    end else begin : g_body
      assign line_wr[k] = row_val[k-1];
    end
    bmf_line_cell u_line (
      .clk_i     (clk_i),
      .ctrl_i    (line_ctrl),
      .wr_data_i (line_wr[k]),
      .row_o     (row_val[k])
    );
  end

  logic [SUM_W-1:0] vsum;

  always_comb begin
    vsum = SUM_W'(s1_pix_q);
    for (int k = 0; k < LINES; k++) begin
      vsum = vsum + SUM_W'(row_val[k]);
    end
  end

  // Second stage: column sum enters the window chain.
  logic [SUM_W-1:0] s2_vsum_q;
  logic             s2_win_q, s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_free) begin
      s2_vld_q <= s1_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_vsum_q <= vsum;
      s2_win_q  <= s1_win_q;
      s2_last_q <= s1_last_q;
    end
  end

  // The six cells hold the column sums of the six columns left of the current
  // one, oldest in cell 0.
  logic [SUM_W-1:0] cell_sum [LINES];
  logic [SUM_W-1:0] cell_in  [LINES];

  for (genvar k = 0; k < LINES; k++) begin : g_sum
    if (k == LINES - 1) begin : g_tail
      assign cell_in[k] = s2_vsum_q;
    end else begin : g_body
      assign cell_in[k] = cell_sum[k+1];
    end
    bmf_sum_cell u_sum (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s2_go),
      .sum_i   (cell_in[k]),
      .sum_o   (cell_sum[k])
    );
  end

  // Third stage: the window total is the new column sum plus the six cells.
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               s3_win_q, s3_last_q;

  always_comb begin
    total_d = TOTAL_W'(s2_vsum_q);
    for (int k = 0; k < LINES; k++) begin
      total_d = total_d + TOTAL_W'(cell_sum[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      total_q  <= '0;
    end else begin
      if (s3_free) begin
        s3_vld_q <= s2_go;
      end
      if (s2_go) begin
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      s3_win_q  <= s2_win_q;
      s3_last_q <= s2_last_q;
    end
  end

  // Output register.
  logic out_win_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s3_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_go) begin
      out_win_q  <= s3_win_q;
      out_last_q <= s3_last_q;
    end
  end

  bmf_div49 u_div (
    .clk_i   (clk_i),
    .en_i    (s3_go),
    .total_i (total_q),
    .win_i   (s3_win_q),
    .mean_o  (m_axis_tdata)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_win_q;
  assign m_axis_tlast  = out_last_q;

endmodule
